// ----- src/bffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, codes and defaults for the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int CHUNK_BYTES_DEF = 16;
    localparam int MAP_WORDS_DEF   = 8;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam int ENTRY_W = 24;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    localparam logic REG_WORDS_IN_USE = 1'b0;
    localparam logic REG_MAX_OBJECTS  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] size_bytes;
        logic [7:0]  chunk_offset;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  found_offset;
        logic [15:0] object_bytes;
    } t_out_word;

    typedef struct packed {
        logic [3:0] words_in_use;
        logic [5:0] max_objects;
    } t_cfg;

endpackage

// ----- src/bffa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bffa_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_regs
// APB register file: region size in bitmap words and object table limit.
// ----------------------------------------------------------------------------
module bffa_regs
    import bffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.words_in_use <= 4'd8;
            r_cfg.max_objects  <= 6'd32;
        end else if (s_wr) begin
            if (paddr[2] == REG_WORDS_IN_USE) begin
                r_cfg.words_in_use <= pwdata[3:0];
            end else begin
                r_cfg.max_objects <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_OBJECTS) begin
            prdata = {26'd0, r_cfg.max_objects};
        end else begin
            prdata = {28'd0, r_cfg.words_in_use};
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bitmap_first_fit_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// First-fit chunk allocator over a used-chunk bitmap and an object table.
// ----------------------------------------------------------------------------
// Usage: present a word on i_in_data with i_in_valid; it is taken on a cycle
// where o_in_stall is low. op allocate rounds size_bytes up to chunks and
// marks the lowest free run; free and query look chunk_offset up in the
// object table. One result word comes out on o_out_data with o_out_valid and
// holds until a cycle where i_out_stall is low; the next word is taken the
// cycle after that.
// Steps: one bitmap bit is examined per cycle, so allocate scans the region
// chunk by chunk and then marks the found run one chunk at a time. Free and
// query read each table entry searched from the RAM and then compare it; free
// then moves the last entry into the hole and clears the object's chunks one
// by one. Zero size and table full answer the cycle after the word is taken;
// no space and not found answer once the scan or search ends.
// Reset clears the bitmap and the object count at once; the table RAM needs no
// clearing since only entries below the count are read. Configuration goes through
// the APB port while the block is idle; the user must ensure this, the block does not.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit
    import bffa_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int MAP_WORDS   = MAP_WORDS_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PHYS_WORDS = (MAP_WORDS > 8) ? 8 : MAP_WORDS;
    localparam int MAP_BITS   = PHYS_WORDS * 32;
    localparam int IDX_W      = $clog2(MAP_BITS);
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ACC_RAW    = $clog2((MAP_BITS + 1) * CHUNK_BYTES + 1) + 1;
    localparam int ACC_W      = (ACC_RAW > 17) ? ACC_RAW : 17;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_MARK = 4'd2;
    localparam logic [3:0] S_TRD  = 4'd3;
    localparam logic [3:0] S_TCMP = 4'd4;
    localparam logic [3:0] S_MOVE = 4'd5;
    localparam logic [3:0] S_CLR  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    t_cfg s_cfg;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [15:0]         r_bytes, n_bytes;
    logic [7:0]          r_off, n_off;
    logic [8:0]          r_idx, n_idx;
    logic [8:0]          r_run, n_run;
    logic [7:0]          r_start, n_start;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [AW-1:0]       r_e, n_e;
    logic [15:0]         r_sz, n_sz;
    t_out_word           r_res, n_res;
    logic [MAP_BITS-1:0] r_map, n_map;

    logic                s_we;
    logic [AW-1:0]       s_waddr;
    logic [ENTRY_W-1:0]  s_wdata;
    logic [AW-1:0]       s_raddr;
    logic [ENTRY_W-1:0]  s_rdata;

    logic [CNT_W-1:0]    s_last;
    logic [ACC_W-1:0]    s_acc_inc;
    logic [7:0]          s_start;
    logic                s_full;
    logic [ACC_W-1:0]    s_chunk;

    bffa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    bffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign s_chunk   = ACC_W'(CHUNK_BYTES);
    assign s_last    = r_cnt - 1'b1;
    assign s_acc_inc = r_acc + s_chunk;
    assign s_start   = (r_run == 9'd0) ? r_idx[7:0] : r_start;
    assign s_full    = (10'(r_cnt) >= 10'(s_cfg.max_objects))
                     || (10'(r_cnt) >= 10'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_bytes = r_bytes;
        n_off   = r_off;
        n_idx   = r_idx;
        n_run   = r_run;
        n_start = r_start;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_e     = r_e;
        n_sz    = r_sz;
        n_res   = r_res;
        n_map   = r_map;
        s_we    = 1'b0;
        s_waddr = r_e;
        s_wdata = s_rdata;
        s_raddr = r_k[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op               = i_in_data.op;
                    n_bytes            = i_in_data.size_bytes;
                    n_off              = i_in_data.chunk_offset;
                    n_res.status       = ST_NOTFOUND;
                    n_res.found_offset = i_in_data.chunk_offset;
                    n_res.object_bytes = 16'd0;
                    n_idx              = 9'd0;
                    n_run              = 9'd0;
                    n_acc              = '0;
                    n_k                = '0;
                    priority if (i_in_data.op == OP_ALLOC) begin
                        priority if (i_in_data.size_bytes == 16'd0) begin
                            n_res.status = ST_ZERO;
                            n_state      = S_DONE;
                        end else if (s_full) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_in_data.op == OP_FREE || i_in_data.op == OP_QUERY) begin
                        n_state = S_TRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx[8:5] >= s_cfg.words_in_use || r_idx >= 9'(MAP_BITS)) begin
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_DONE;
                end else if (r_map[r_idx[IDX_W-1:0]]) begin
                    // used chunk: restart the run
                    n_run = 9'd0;
                    n_acc = '0;
                    n_idx = r_idx + 9'd1;
                end else begin
                    n_start = s_start;
                    n_run   = r_run + 9'd1;
                    n_acc   = s_acc_inc;
                    if (s_acc_inc >= {{(ACC_W-16){1'b0}}, r_bytes}) begin
                        n_idx   = {1'b0, s_start};
                        n_state = S_MARK;
                    end else begin
                        n_idx = r_idx + 9'd1;
                    end
                end
            end
            S_MARK: begin
                n_map[r_idx[IDX_W-1:0]] = 1'b1;
                n_idx = r_idx + 9'd1;
                n_run = r_run - 9'd1;
                if (r_run == 9'd1) begin
                    s_we               = 1'b1;
                    s_waddr            = r_cnt[AW-1:0];
                    s_wdata            = {r_start, r_bytes};
                    n_cnt              = r_cnt + 1'b1;
                    n_res.status       = ST_OK;
                    n_res.found_offset = r_start;
                    n_res.object_bytes = r_bytes;
                    n_state            = S_DONE;
                end
            end
            S_TRD: begin
                if (r_k >= r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    s_raddr = r_k[AW-1:0];
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                if (s_rdata[23:16] == r_off) begin
                    n_sz = s_rdata[15:0];
                    n_e  = r_k[AW-1:0];
                    if (r_op == OP_QUERY) begin
                        n_res.status       = ST_OK;
                        n_res.object_bytes = s_rdata[15:0];
                        n_state            = S_DONE;
                    end else begin
                        // fetch the last entry to fill the hole
                        s_raddr = s_last[AW-1:0];
                        n_state = S_MOVE;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_MOVE: begin
                s_we    = 1'b1;
                s_waddr = r_e;
                s_wdata = s_rdata;
                n_cnt   = s_last;
                n_idx   = {1'b0, r_off};
                n_acc   = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                if (r_acc >= {{(ACC_W-16){1'b0}}, r_sz} || r_idx >= 9'(MAP_BITS)) begin
                    n_res.status       = ST_OK;
                    n_res.object_bytes = r_sz;
                    n_state            = S_DONE;
                end else begin
                    n_map[r_idx[IDX_W-1:0]] = 1'b0;
                    n_acc = s_acc_inc;
                    n_idx = r_idx + 9'd1;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_map   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_map   <= n_map;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_bytes <= n_bytes;
        r_off   <= n_off;
        r_idx   <= n_idx;
        r_run   <= n_run;
        r_start <= n_start;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_e     <= n_e;
        r_sz    <= n_sz;
        r_res   <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data  = r_res;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, query and undefined-op words into the first-fit allocator under
// random valid/stall gaps and APB register changes, and checks every result
// word against a bitmap and object-table predictor kept in the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import bffa_pkg::*;

    localparam int NUM_WORDS       = 8;
    localparam int NUM_SLOTS       = 32;
    localparam int BYTES_PER_CHUNK = 16;
    localparam int CYCLE_CAP       = 8000000;

    localparam logic [1:0] OP_UNDEF = 2'd3;

    class alloc_scoreboard;
        bit [31:0]  used_map [NUM_WORDS];
        bit [7:0]   slot_off [NUM_SLOTS];
        bit [15:0]  slot_bytes [NUM_SLOTS];
        int         live_count;
        int         region_words;
        int         slot_cap;
        t_out_word  pending [$];
        int         errors;

        function void clear();
            foreach (used_map[k]) used_map[k] = '0;
            live_count = 0;
            region_words = 8;
            slot_cap = 32;
            pending.delete();
            errors = 0;
        endfunction

        function bit chunk_taken(int i);
            return used_map[(i >> 5) % NUM_WORDS][i & 31];
        endfunction

        function int lookup(bit [7:0] off);
            for (int k = 0; k < live_count; k++)
                if (slot_off[k] == off) return k;
            return -1;
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            int need, total, run, start, e, stop, cap;
            bit got;
            r.status = ST_NOTFOUND;
            r.found_offset = w.chunk_offset;
            r.object_bytes = '0;
            if (w.op == OP_ALLOC) begin
                cap = slot_cap > NUM_SLOTS ? NUM_SLOTS : slot_cap;
                need = (int'(w.size_bytes) + BYTES_PER_CHUNK - 1) / BYTES_PER_CHUNK;
                total = (region_words > NUM_WORDS ? NUM_WORDS : region_words) * 32;
                if (w.size_bytes == 0) begin
                    r.status = ST_ZERO;
                end else if (live_count >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    r.status = ST_NO_SPACE;
                    run = 0;
                    got = 0;
                    start = 0;
                    if (need <= total) begin
                        for (int i = 0; i < total && !got; i++) begin
                            run = chunk_taken(i) ? 0 : run + 1;
                            if (run == need) begin
                                start = i + 1 - need;
                                got = 1;
                            end
                        end
                    end
                    if (got) begin
                        for (int i = start; i < start + need; i++)
                            used_map[i >> 5][i & 31] = 1'b1;
                        slot_off[live_count] = start[7:0];
                        slot_bytes[live_count] = w.size_bytes;
                        live_count++;
                        r.status = ST_OK;
                        r.found_offset = start[7:0];
                        r.object_bytes = w.size_bytes;
                    end
                end
            end else if (w.op == OP_FREE || w.op == OP_QUERY) begin
                e = lookup(w.chunk_offset);
                if (e >= 0) begin
                    r.status = ST_OK;
                    r.object_bytes = slot_bytes[e];
                    if (w.op == OP_FREE) begin
                        stop = int'(w.chunk_offset)
                               + (int'(slot_bytes[e]) + BYTES_PER_CHUNK - 1) / BYTES_PER_CHUNK;
                        if (stop > NUM_WORDS * 32) stop = NUM_WORDS * 32;
                        slot_off[e] = slot_off[live_count - 1];
                        slot_bytes[e] = slot_bytes[live_count - 1];
                        live_count--;
                        for (int i = w.chunk_offset; i < stop; i++)
                            used_map[i >> 5][i & 31] = 1'b0;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.found_offset !== want.found_offset) begin
                $error("found_offset: expected %0d actual %0d",
                       want.found_offset, got.found_offset);
                errors++;
            end
            if (got.object_bytes !== want.object_bytes) begin
                $error("object_bytes: expected %0d actual %0d",
                       want.object_bytes, got.object_bytes);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard board;
    int  cycle_count;
    bit  hold_off_req;
    bit  sink_hold_active;

    bitmap_first_fit_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stall, with a long hold-off on request; check on accept.
    initial begin
        int gap;
        sink_hold_active = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req) begin
                sink_hold_active = 1;
                i_out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off_req = 0;
                sink_hold_active = 0;
            end
            gap = gap_len();
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid && !hold_off_req) @(posedge i_clk);
            if (o_out_valid) board.check_result(o_out_data);
        end
    end

    // Valid is low on entry; it is dropped after every accept.
    task automatic send_word(t_in_word w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(w);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_op(logic [1:0] op, int bytes, int off);
        t_in_word w;
        w.op = op;
        w.size_bytes = bytes[15:0];
        w.chunk_offset = off[7:0];
        send_word(w);
    endtask

    // Drain: wait until every expected word has come, then the block's tail.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic apb_write(logic reg_sel, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_WORDS_IN_USE) board.region_words = value & 'hF;
        else board.slot_cap = value & 'h3F;
        @(posedge i_clk);
    endtask

    task automatic set_config(int words, int objects);
        drain();
        apb_write(REG_WORDS_IN_USE, words);
        apb_write(REG_MAX_OBJECTS, objects);
    endtask

    // Pick a mostly well-formed word: live offsets for free/query, small sizes.
    task automatic send_random();
        int pick, off, bytes;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        off = $urandom_range(0, 255);
        if (board.live_count > 0 && $urandom_range(0, 9) != 0)
            off = board.slot_off[$urandom_range(0, board.live_count - 1)];
        if (pick < 45) op = OP_ALLOC;
        else if (pick < 80) op = OP_FREE;
        else if (pick < 97) op = OP_QUERY;
        else op = OP_UNDEF;
        case ($urandom_range(0, 9))
            0: bytes = $urandom_range(0, 65535);
            1: bytes = $urandom_range(0, 4096);
            2: bytes = 0;
            default: bytes = $urandom_range(1, 300);
        endcase
        send_op(op, bytes, off);
    endtask

    initial begin
        board = new();
        board.clear();
        hold_off_req = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each op, zero size, no space, full table, unknown offset.
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_ALLOC, 16, 0);
        send_op(OP_ALLOC, 17, 0);
        send_op(OP_QUERY, 0, 1);
        send_op(OP_QUERY, 0, 2);
        send_op(OP_FREE, 0, 1);
        send_op(OP_QUERY, 0, 1);
        send_op(OP_FREE, 0, 255);
        send_op(OP_UNDEF, 65535, 255);
        send_op(OP_ALLOC, 65535, 255);
        send_op(OP_ALLOC, 4096, 0);
        send_op(OP_ALLOC, 16, 0);
        send_op(OP_FREE, 0, 0);
        send_op(OP_FREE, 0, 3);
        send_op(OP_ALLOC, 4080, 0);
        send_op(OP_FREE, 0, 1);
        set_config(1, 1);
        send_op(OP_ALLOC, 600, 0);
        send_op(OP_ALLOC, 8, 0);
        send_op(OP_ALLOC, 8, 0);
        set_config(0, 0);
        send_op(OP_ALLOC, 8, 0);
        set_config(8, 32);
        send_op(OP_FREE, 0, 0);

        // Random phases over several settings, extremes included.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(8, 32);
                1: set_config(1, 4);
                2: set_config(15, 63);
                3: set_config($urandom_range(1, 8), $urandom_range(1, 32));
                4: set_config(2, 1);
                5: set_config(8, 32);
                default: set_config($urandom_range(0, 15), $urandom_range(0, 63));
            endcase
            if (phase == 3) hold_off_req = 1;
            for (int n = 0; n < 240; n++) begin
                if (phase == 5 && n == 100) drain();
                send_random();
            end
        end

        while (hold_off_req || sink_hold_active) @(posedge i_clk);
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/bffa_pkg.sv
src/bffa_ram.sv
src/bffa_regs.sv
src/bitmap_first_fit_allocator_unit.sv
tb/sv/testbench.sv
